### design/llim_pkg.sv
// ----------------------------------------------------------------------------
// Linked peak limiter package
// Widths, register indexes and the lane control bundle shared by the limiter.
// ----------------------------------------------------------------------------
package llim_pkg;

  // Frame layout.
  localparam int NUM_CH     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int GAIN_W     = 17;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  // Divider geometry: a 32-bit dividend over a 16-bit divisor.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Gain and level constants.
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;
  localparam logic [15:0]       CEIL_MIN   = 16'd328;
  localparam logic [15:0]       CEIL_MAX   = 16'd32768;
  localparam logic [15:0]       POS_FULL   = 16'd32767;
  localparam logic [GAIN_W-1:0] STEP_MIN   = 17'd1;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  RST_CHANNELS = 4'd2;
  localparam logic [15:0]       RST_CEILING  = 16'd32768;
  localparam logic [GAIN_W-1:0] RST_ATTACK   = 17'd683;
  localparam logic [GAIN_W-1:0] RST_RELEASE  = 17'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd4;

  // Strobes from the sequencer to every lane.
  typedef struct packed {
    logic load;    // capture the sample on an input transfer
    logic scale;   // multiply the magnitude by the settled gain
    logic bypass;  // limiter disabled: pass the sample unchanged
  } llim_lane_ctl_t;

endpackage

### design/linked_peak_limiter.sv
// ----------------------------------------------------------------------------
// Linked peak limiter: when limiting, a frame passes the peak, product, test, divide,
// attack, update, scale and output states; with no limit needed it skips divide and
// attack, and when disabled it goes straight to output. One frame at a time; the serial
// ceiling/peak divider sets the worst case. A new frame is taken only back in idle.
// Synchronous active-low reset: gain to unity, registers to defaults, no frame held.
// ----------------------------------------------------------------------------
module linked_peak_limiter import llim_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // Input frame
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   in_sample_0,
  input  logic signed [SAMPLE_W-1:0]   in_sample_1,
  input  logic signed [SAMPLE_W-1:0]   in_sample_2,
  input  logic signed [SAMPLE_W-1:0]   in_sample_3,
  input  logic signed [SAMPLE_W-1:0]   in_sample_4,
  input  logic signed [SAMPLE_W-1:0]   in_sample_5,
  input  logic signed [SAMPLE_W-1:0]   in_sample_6,
  input  logic signed [SAMPLE_W-1:0]   in_sample_7,
  // Limited frame
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_0,
  output logic signed [SAMPLE_W-1:0]   out_1,
  output logic signed [SAMPLE_W-1:0]   out_2,
  output logic signed [SAMPLE_W-1:0]   out_3,
  output logic signed [SAMPLE_W-1:0]   out_4,
  output logic signed [SAMPLE_W-1:0]   out_5,
  output logic signed [SAMPLE_W-1:0]   out_6,
  output logic signed [SAMPLE_W-1:0]   out_7,
  output logic [GAIN_W-1:0]            out_applied_gain
);

  typedef enum logic [3:0] {
    S_IDLE, S_PEAK, S_PROD, S_TEST, S_DIV, S_ATK, S_UPD, S_SCALE, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [CNT_W-1:0]  channels_r;
  logic [15:0]       ceiling_r;
  logic [GAIN_W-1:0] attack_r;
  logic [GAIN_W-1:0] release_r;
  logic              enable_r;

  // Working registers.
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] gain_nxt;
  logic [GAIN_W-1:0] target_r;
  logic [32:0]       pg_r;
  logic [32:0]       pg_nxt;
  logic [33:0]       atk_r;
  logic [33:0]       atk_nxt;
  logic              bypass_r;
  logic              out_valid_r;
  logic signed [SAMPLE_W-1:0] out_smp_r [NUM_CH];
  logic [GAIN_W-1:0] applied_r;

  // Effective register values, saturated into their legal ranges.
  logic [CNT_W-1:0]  n_eff;
  logic [15:0]       c_eff;
  logic [15:0]       c_pos;
  logic [GAIN_W-1:0] a_eff;
  logic [GAIN_W-1:0] r_eff;

  logic              in_xfer;
  logic              need_limit;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [MAG_W-1:0]  peak;
  logic [GAIN_W-1:0] gap;
  logic [33:0]       d_sum;
  logic [17:0]       d_val;
  logic [17:0]       g_sub;
  logic [17:0]       g_add;

  llim_lane_ctl_t             lane_ctl;
  logic signed [SAMPLE_W-1:0] in_smp   [NUM_CH];
  logic [MAG_W-1:0]           lane_mag [NUM_CH];
  logic signed [SAMPLE_W-1:0] lane_res [NUM_CH];
  logic                       lane_act [NUM_CH];

  // Register saturation.
  always_comb begin
    if (channels_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (channels_r > CNT_W'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = channels_r;
    end
    if (ceiling_r < CEIL_MIN) begin
      c_eff = CEIL_MIN;
    end else if (ceiling_r > CEIL_MAX) begin
      c_eff = CEIL_MAX;
    end else begin
      c_eff = ceiling_r;
    end
    c_pos = (c_eff > POS_FULL) ? POS_FULL : c_eff;
    if (attack_r < STEP_MIN) begin
      a_eff = STEP_MIN;
    end else if (attack_r > UNITY_GAIN) begin
      a_eff = UNITY_GAIN;
    end else begin
      a_eff = attack_r;
    end
    if (release_r < STEP_MIN) begin
      r_eff = STEP_MIN;
    end else if (release_r > UNITY_GAIN) begin
      r_eff = UNITY_GAIN;
    end else begin
      r_eff = release_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign lane_ctl.load   = in_xfer;
  assign lane_ctl.scale  = (state_r == S_SCALE);
  assign lane_ctl.bypass = bypass_r;

  assign in_smp[0] = in_sample_0;
  assign in_smp[1] = in_sample_1;
  assign in_smp[2] = in_sample_2;
  assign in_smp[3] = in_sample_3;
  assign in_smp[4] = in_sample_4;
  assign in_smp[5] = in_sample_5;
  assign in_smp[6] = in_sample_6;
  assign in_smp[7] = in_sample_7;

  // Channel lanes; channels beyond MAX_CHANNELS are always silent.
  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    assign lane_act[i] = (CNT_W'(i) < n_eff);
    if (i < MAX_CHANNELS) begin : g_on
      llim_lane u_lane (
        .clk      (clk),
        .ctl      (lane_ctl),
        .active   (lane_act[i]),
        .sample   (in_smp[i]),
        .gain     (gain_r),
        .ceil_pos (c_pos),
        .ceil_neg (c_eff),
        .mag      (lane_mag[i]),
        .result   (lane_res[i])
      );
    end else begin : g_off
      assign lane_mag[i] = '0;
      assign lane_res[i] = '0;
    end
  end

  // Peak across the lanes.
  llim_peak u_peak (
    .clk  (clk),
    .en   (state_r == S_PEAK),
    .mag  (lane_mag),
    .peak (peak)
  );

  // Limit test: peak times gain above the ceiling at unity scale.
  assign pg_nxt     = {17'b0, peak} * {16'b0, gain_r};
  assign need_limit = (peak != '0) && (pg_r > {1'b0, c_eff, 16'h0000});
  assign div_start  = (state_r == S_TEST) && need_limit;

  llim_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({c_eff, 16'h0000}),
    .divisor  (peak),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Attack product and the gain update.
  always_comb begin
    gap     = gain_r - target_r;
    atk_nxt = {17'b0, gap} * {17'b0, a_eff};
    d_sum   = atk_r + 34'h0_0000_FFFF;
    d_val   = d_sum[33:16];
    g_sub   = {1'b0, gain_r} - d_val;
    g_add   = {1'b0, gain_r} + {1'b0, r_eff};
    if (target_r < gain_r) begin
      gain_nxt = (g_sub < {1'b0, target_r}) ? target_r : g_sub[GAIN_W-1:0];
    end else if (gain_r < UNITY_GAIN) begin
      gain_nxt = (g_add > {1'b0, UNITY_GAIN}) ? UNITY_GAIN : g_add[GAIN_W-1:0];
    end else begin
      gain_nxt = gain_r;
    end
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      channels_r  <= RST_CHANNELS;
      ceiling_r   <= RST_CEILING;
      attack_r    <= RST_ATTACK;
      release_r   <= RST_RELEASE;
      enable_r    <= 1'b1;
      gain_r      <= UNITY_GAIN;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            bypass_r <= !enable_r;
            if (!enable_r) begin
              gain_r  <= UNITY_GAIN;
              state_r <= S_OUT;
            end else begin
              state_r <= S_PEAK;
            end
          end
        end
        S_PEAK: begin
          state_r <= S_PROD;
        end
        S_PROD: begin
          pg_r    <= pg_nxt;
          state_r <= S_TEST;
        end
        S_TEST: begin
          if (need_limit) begin
            state_r <= S_DIV;
          end else begin
            target_r <= UNITY_GAIN;
            state_r  <= S_UPD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            target_r <= div_quo[GAIN_W-1:0];
            state_r  <= S_ATK;
          end
        end
        S_ATK: begin
          atk_r   <= atk_nxt;
          state_r <= S_UPD;
        end
        S_UPD: begin
          gain_r  <= gain_nxt;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < NUM_CH; i++) begin
              out_smp_r[i] <= lane_res[i];
            end
            applied_r   <= gain_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // Configuration writes; disabling also returns the gain to unity.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHANNELS: channels_r <= cfg_wdata[CNT_W-1:0];
          REG_CEILING:  ceiling_r  <= cfg_wdata[15:0];
          REG_ATTACK:   attack_r   <= cfg_wdata[GAIN_W-1:0];
          REG_RELEASE:  release_r  <= cfg_wdata[GAIN_W-1:0];
          REG_ENABLE: begin
            enable_r <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              gain_r <= UNITY_GAIN;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_0            = out_smp_r[0];
  assign out_1            = out_smp_r[1];
  assign out_2            = out_smp_r[2];
  assign out_3            = out_smp_r[3];
  assign out_4            = out_smp_r[4];
  assign out_5            = out_smp_r[5];
  assign out_6            = out_smp_r[6];
  assign out_7            = out_smp_r[7];
  assign out_applied_gain = applied_r;

`ifndef SYNTH
  // The gain never rises above unity.
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= UNITY_GAIN)
    else $error("gain above unity");

  // A new result appears only from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // An input transfer always starts work on the frame.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("frame taken without leaving idle");
`endif

endmodule

### design/llim_lane.sv
// ----------------------------------------------------------------------------
// Limiter channel lane
// Holds one channel sample, reports its magnitude and scales it by the gain
// with rounding and a clamp to the ceiling.
// ----------------------------------------------------------------------------
module llim_lane import llim_pkg::*; (
  input  logic                       clk,
  input  llim_lane_ctl_t             ctl,
  input  logic                       active,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]          gain,
  input  logic [15:0]                ceil_pos,
  input  logic [15:0]                ceil_neg,
  output logic [MAG_W-1:0]           mag,
  output logic signed [SAMPLE_W-1:0] result
);

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       act_r;
  logic [MAG_W-1:0]           mag_r;
  logic [MAG_W-1:0]           mag_nxt;
  logic [31:0]                prod_r;
  logic [31:0]                prod_nxt;
  logic [31:0]                rnd;
  logic [15:0]                q;
  logic [15:0]                pos_v;
  logic [15:0]                neg_m;

  // Magnitude of the incoming sample; full-scale negative maps to 32768.
  always_comb begin
    if (!active) begin
      mag_nxt = '0;
    end else if (sample[SAMPLE_W-1]) begin
      mag_nxt = MAG_W'(~sample) + MAG_W'(1);
    end else begin
      mag_nxt = MAG_W'(sample);
    end
  end

  // The product peaks at 2^31, so 32 bits hold it.
  assign prod_nxt = {16'b0, mag_r} * {15'b0, gain};

  // Sample capture and gain multiply.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= sample;
      act_r    <= active;
      mag_r    <= mag_nxt;
    end
    if (ctl.scale) begin
      prod_r <= prod_nxt;
    end
  end

  // Round half away from zero, then clamp each sign to its own limit.
  always_comb begin
    rnd   = prod_r + 32'h0000_8000;
    q     = rnd[31:16];
    pos_v = (q > ceil_pos) ? ceil_pos : q;
    neg_m = (q > ceil_neg) ? ceil_neg : q;
    if (!act_r) begin
      result = '0;
    end else if (ctl.bypass) begin
      result = sample_r;
    end else if (sample_r[SAMPLE_W-1]) begin
      result = SAMPLE_W'(16'd0 - neg_m);
    end else begin
      result = SAMPLE_W'(pos_v);
    end
  end

  assign mag = mag_r;

endmodule

### design/llim_peak.sv
// ----------------------------------------------------------------------------
// Limiter peak merge
// Registered maximum over the magnitudes reported by all lanes.
// ----------------------------------------------------------------------------
module llim_peak import llim_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag [NUM_CH],
  output logic [MAG_W-1:0] peak
);

  logic [MAG_W-1:0] lvl1 [NUM_CH/2];
  logic [MAG_W-1:0] lvl2 [NUM_CH/4];
  logic [MAG_W-1:0] peak_nxt;
  logic [MAG_W-1:0] peak_r;

  // Three-level comparison tree.
  always_comb begin
    for (int i = 0; i < NUM_CH/2; i++) begin
      lvl1[i] = (mag[2*i] > mag[2*i+1]) ? mag[2*i] : mag[2*i+1];
    end
    for (int i = 0; i < NUM_CH/4; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    peak_nxt = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      peak_r <= peak_nxt;
    end
  end

  assign peak = peak_r;

endmodule

### design/llim_div.sv
// ----------------------------------------------------------------------------
// Limiter target divider
// Restoring divider, one quotient bit per cycle, for ceiling over peak.
// ----------------------------------------------------------------------------
module llim_div import llim_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [MAG_W:0]       rem_r;
  logic [MAG_W:0]       rem_nxt;
  logic [MAG_W:0]       rem_sh;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     quo_nxt;
  logic [MAG_W-1:0]     dvs_r;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_r[MAG_W-1:0], quo_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Linked peak limiter testbench
// Sends audio frames through the limiter under random flow control on both
// channels. A frame-by-frame gain tracker predicts each limited frame, which is
// compared field by field as it leaves the block. Directed frames cover the
// register extremes, out-of-range settings, bypass and the full-scale clamp.
// Random phases then run loud bursts followed by quiet recovery.
// ----------------------------------------------------------------------------
module testbench;
  import llim_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 48;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_FRAMES   = 200;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] frame_t;

  typedef struct packed {
    frame_t              ch;
    logic [GAIN_W-1:0]   gain;
  } limited_t;

  typedef enum {LVL_QUIET, LVL_LOUD, LVL_NOISE} level_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_0, in_sample_1, in_sample_2, in_sample_3;
  logic signed [SAMPLE_W-1:0] in_sample_4, in_sample_5, in_sample_6, in_sample_7;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
  logic [GAIN_W-1:0]          out_applied_gain;

  // Settings and gain as the tracker sees them.
  logic [CNT_W-1:0]  cfg_channels = RST_CHANNELS;
  logic [15:0]       cfg_ceiling  = RST_CEILING;
  logic [GAIN_W-1:0] cfg_attack   = RST_ATTACK;
  logic [GAIN_W-1:0] cfg_release  = RST_RELEASE;
  logic              cfg_enable   = 1'b1;
  logic [GAIN_W-1:0] tracked_gain = UNITY_GAIN;

  limited_t    limited_q[$];
  int unsigned frames_checked = 0;
  int unsigned fault_count    = 0;
  bit          send_gaps;
  bit          sink_gaps;
  bit          hold_req;

  linked_peak_limiter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_0      (in_sample_0),
    .in_sample_1      (in_sample_1),
    .in_sample_2      (in_sample_2),
    .in_sample_3      (in_sample_3),
    .in_sample_4      (in_sample_4),
    .in_sample_5      (in_sample_5),
    .in_sample_6      (in_sample_6),
    .in_sample_7      (in_sample_7),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_0            (out_0),
    .out_1            (out_1),
    .out_2            (out_2),
    .out_3            (out_3),
    .out_4            (out_4),
    .out_5            (out_5),
    .out_6            (out_6),
    .out_7            (out_7),
    .out_applied_gain (out_applied_gain)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Register write as the block applies it; disabling snaps the gain to unity.
  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHANNELS: cfg_channels = data[CNT_W-1:0];
      REG_CEILING:  cfg_ceiling  = data[15:0];
      REG_ATTACK:   cfg_attack   = data;
      REG_RELEASE:  cfg_release  = data;
      REG_ENABLE: begin
        cfg_enable = data[0];
        if (!data[0]) tracked_gain = UNITY_GAIN;
      end
      default: ;
    endcase
  endfunction

  // Works out the limited frame and moves the tracked gain on by one frame.
  function automatic limited_t limit_frame(input frame_t smp);
    limited_t          res;
    int unsigned       n, peak, mag;
    longint unsigned   c, a, r, g, w, d, q;
    int                v, hi, lo;
    res  = '0;
    n    = clamp_range(cfg_channels, 1, NUM_CH);
    c    = clamp_range(cfg_ceiling, CEIL_MIN, CEIL_MAX);
    a    = clamp_range(cfg_attack, 1, UNITY_GAIN);
    r    = clamp_range(cfg_release, 1, UNITY_GAIN);
    peak = 0;
    if (!cfg_enable) begin
      tracked_gain = UNITY_GAIN;
      for (int i = 0; i < n; i++) res.ch[i] = smp[i];
      res.gain = UNITY_GAIN;
      return res;
    end
    if (tracked_gain > UNITY_GAIN) tracked_gain = UNITY_GAIN;
    for (int i = 0; i < n; i++) begin
      v   = $signed(smp[i]);
      mag = (v < 0) ? -v : v;
      if (mag > peak) peak = mag;
    end
    // Target gain only when the peak at the present gain would pass the ceiling.
    g = tracked_gain;
    w = UNITY_GAIN;
    if (peak != 0 && longint'(peak) * g > c * UNITY_GAIN) w = (c * UNITY_GAIN) / peak;
    if (w < g) begin
      d = ((g - w) * a + 65535) >> 16;
      g = g - d;
      if (g < w) g = w;
    end else if (g < UNITY_GAIN) begin
      g = g + r;
      if (g > UNITY_GAIN) g = UNITY_GAIN;
    end
    tracked_gain = g[GAIN_W-1:0];
    // Scale with rounding half away from zero, then clamp to the ceiling.
    hi = (c > POS_FULL) ? POS_FULL : int'(c);
    lo = -int'(c);
    for (int i = 0; i < n; i++) begin
      v   = $signed(smp[i]);
      mag = (v < 0) ? -v : v;
      q   = (longint'(mag) * g + 32768) >> 16;
      v   = (v < 0) ? -int'(q) : int'(q);
      if (v > hi) v = hi;
      else if (v < lo) v = lo;
      res.ch[i] = v[SAMPLE_W-1:0];
    end
    res.gain = tracked_gain;
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_t uniform_frame(input logic [SAMPLE_W-1:0] v);
    return {NUM_CH{v}};
  endfunction

  function automatic frame_t make_frame(input level_t lvl);
    frame_t f;
    int     m, v;
    for (int i = 0; i < NUM_CH; i++) begin
      case (lvl)
        LVL_QUIET: begin
          m = $urandom_range(0, 1023);
          v = $urandom_range(0, 1) ? -m : m;
        end
        LVL_LOUD: begin
          m = $urandom_range(16384, 32768);
          v = (m == 32768 || $urandom_range(0, 1)) ? -m : m;
        end
        default: v = $urandom_range(0, 65535);
      endcase
      f[i] = v[SAMPLE_W-1:0];
    end
    return f;
  endfunction

  // One input transfer; the expectation is queued at the accepting edge.
  task automatic push_frame(input frame_t smp);
    int unsigned gap;
    gap = pick_gap(send_gaps);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_sample_0 <= smp[0];
    in_sample_1 <= smp[1];
    in_sample_2 <= smp[2];
    in_sample_3 <= smp[3];
    in_sample_4 <= smp[4];
    in_sample_5 <= smp[5];
    in_sample_6 <= smp[6];
    in_sample_7 <= smp[7];
    do @(posedge clk); while (in_ready !== 1'b1);
    limited_q.push_back(limit_frame(smp));
  endtask

  // Stops offering frames and waits until every limited frame has come out.
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    apply_setting(idx, data[CFG_DATA_W-1:0]);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic program_settings(input int unsigned chans, input int unsigned ceil_lvl,
                                  input int unsigned atk, input int unsigned rel);
    cfg_write(REG_CHANNELS, chans);
    cfg_write(REG_CEILING, ceil_lvl);
    cfg_write(REG_ATTACK, atk);
    cfg_write(REG_RELEASE, rel);
  endtask

  // Reset values: two channels, full-scale ceiling, so no limiting happens.
  task automatic test_default_settings();
    frame_t f;
    push_frame('0);
    push_frame(uniform_frame(16'h7fff));
    push_frame(uniform_frame(16'h8000));
    f    = uniform_frame(16'h5555);
    f[0] = 16'h0001;
    f[1] = 16'hffff;
    push_frame(f);
  endtask

  // Fastest and slowest attack and release around a half-scale ceiling.
  task automatic test_attack_release();
    frame_t f;
    wait_drained();
    program_settings(NUM_CH, 16384, UNITY_GAIN, UNITY_GAIN);
    f    = '0;
    f[7] = 16'h8000;
    push_frame(f);
    push_frame(uniform_frame(16'h0100));
    push_frame(uniform_frame(16'h7fff));
    wait_drained();
    cfg_write(REG_ATTACK, 1);
    cfg_write(REG_RELEASE, 1);
    push_frame(uniform_frame(16'h8000));
    push_frame(uniform_frame(16'h8000));
    push_frame(uniform_frame(16'h0010));
  endtask

  // Settings outside their ranges saturate; spare register indexes do nothing.
  task automatic test_register_saturation();
    frame_t f;
    wait_drained();
    cfg_write(REG_CHANNELS, 0);
    f    = uniform_frame(16'h7fff);
    f[0] = 16'h4000;
    push_frame(f);
    wait_drained();
    program_settings(9, 0, 0, 0);
    push_frame(uniform_frame(16'h7fff));
    wait_drained();
    program_settings(15, 16'hffff, 17'h1ffff, 17'h1ffff);
    push_frame(uniform_frame(16'h8000));
    push_frame(uniform_frame(16'h0200));
    wait_drained();
    for (int idx = REG_ENABLE + 1; idx < 2 ** CFG_IDX_W; idx++) begin
      cfg_write(idx[CFG_IDX_W-1:0], 17'h1ffff);
      cfg_write(idx[CFG_IDX_W-1:0], 0);
    end
    push_frame(make_frame(LVL_LOUD));
  endtask

  // Disabling mid-attack drops the gain to unity and passes samples through.
  task automatic test_bypass();
    frame_t f;
    wait_drained();
    program_settings(NUM_CH, 4000, 30000, 50);
    push_frame(uniform_frame(16'h7fff));
    push_frame(uniform_frame(16'h7fff));
    wait_drained();
    cfg_write(REG_ENABLE, 0);
    push_frame(uniform_frame(16'h8000));
    f    = uniform_frame(16'h8001);
    f[3] = 16'h7ffe;
    f[6] = 16'h0000;
    push_frame(f);
    wait_drained();
    cfg_write(REG_ENABLE, 1);
    push_frame(uniform_frame(16'h0040));
    push_frame(uniform_frame(16'h7fff));
  endtask

  // The receiver holds off for a long stretch while frames keep coming.
  task automatic test_output_stall();
    wait_drained();
    program_settings(4, 12000, 9000, 400);
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    for (int i = 0; i < 20; i++) push_frame(make_frame(i % 3 == 2 ? LVL_QUIET : LVL_LOUD));
    send_gaps = 1'b1;
  endtask

  task automatic program_random_settings();
    int unsigned roll, atk, rel;
    roll = $urandom_range(0, 99);
    if (roll < 80) cfg_write(REG_CHANNELS, $urandom_range(1, NUM_CH));
    else cfg_write(REG_CHANNELS, $urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 85) cfg_write(REG_CEILING, $urandom_range(CEIL_MIN, CEIL_MAX));
    else cfg_write(REG_CEILING, $urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 40) atk = $urandom_range(1, 4096);
    else if (roll < 80) atk = $urandom_range(4096, UNITY_GAIN);
    else atk = $urandom_range(0, 17'h1ffff);
    cfg_write(REG_ATTACK, atk);
    roll = $urandom_range(0, 99);
    if (roll < 50) rel = $urandom_range(1, 512);
    else if (roll < 80) rel = $urandom_range(512, UNITY_GAIN);
    else rel = $urandom_range(0, 17'h1ffff);
    cfg_write(REG_RELEASE, rel);
    cfg_write(REG_ENABLE, ($urandom_range(0, 99) < 85) ? 1 : 0);
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_ENABLE + 1, 2 ** CFG_IDX_W - 1)), $urandom());
  endtask

  // Mostly loud bursts followed by quiet recovery, with noise runs between.
  task automatic test_random_traffic();
    int unsigned sent, burst, tail;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      program_random_settings();
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        send_gaps = ($urandom_range(0, 4) != 0);
        sink_gaps = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 9) < 7) begin
          burst = $urandom_range(3, 30);
          tail  = $urandom_range(3, 40);
          for (int i = 0; i < burst; i++)
            push_frame(make_frame($urandom_range(0, 7) == 0 ? LVL_NOISE : LVL_LOUD));
          for (int i = 0; i < tail; i++) push_frame(make_frame(LVL_QUIET));
          sent += burst + tail;
        end else begin
          burst = $urandom_range(1, 20);
          for (int i = 0; i < burst; i++) push_frame(make_frame(LVL_NOISE));
          sent += burst;
        end
      end
    end
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Result receiver: random stalls, plus the long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap(sink_gaps);
      end
    end
  end

  // Compares each output transfer with the oldest expected frame.
  initial begin : frame_checker
    limited_t exp_frame;
    frame_t   got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        got = {out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};
        if (limited_q.size() == 0) begin
          $display("%0t: unexpected frame, gain %0d", $time, out_applied_gain);
          fault_count++;
        end else begin
          exp_frame = limited_q.pop_front();
          for (int i = 0; i < NUM_CH; i++) begin
            if (got[i] !== exp_frame.ch[i]) begin
              $display("%0t: frame %0d out_%0d expected %0d, got %0d", $time,
                       frames_checked, i, $signed(exp_frame.ch[i]), $signed(got[i]));
              fault_count++;
            end
          end
          if (out_applied_gain !== exp_frame.gain) begin
            $display("%0t: frame %0d applied_gain expected %0d, got %0d", $time,
                     frames_checked, exp_frame.gain, out_applied_gain);
            fault_count++;
          end
        end
        frames_checked++;
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_sample_0 = '0;
    in_sample_1 = '0;
    in_sample_2 = '0;
    in_sample_3 = '0;
    in_sample_4 = '0;
    in_sample_5 = '0;
    in_sample_6 = '0;
    in_sample_7 = '0;
    send_gaps   = 1'b1;
    sink_gaps   = 1'b1;
    hold_req    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_default_settings();
    test_attack_release();
    test_register_saturation();
    test_bypass();
    test_output_stall();
    test_random_traffic();

    wait_drained();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
